### hdl/dbam_pkg.sv
// Shared types and constants of the disk block allocation map.
package dbam_pkg;

  localparam int NUM_BLOCKS_DEF = 64;

  localparam int OPCODE_W = 3;
  localparam int OWNER_W  = 8;
  localparam int BLK_W    = 6;
  localparam int RUN_W    = 7;
  localparam int STATUS_W = 3;
  localparam int TAG_W    = 8;

  localparam logic [TAG_W-1:0] TAG_FREE  = 8'h00;
  localparam logic [TAG_W-1:0] TAG_INDEX = 8'hFF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CONTIG     = 3'd0,
    OP_LINKED     = 3'd1,
    OP_INDEX_DECL = 3'd2,
    OP_INDEXED    = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_BLOCKS_UNAV = 3'd2,
    ST_INDEX_UNAV  = 3'd3,
    ST_PENDING     = 3'd4
  } status_e;

  // Owner table address source
  typedef enum logic [1:0] {
    TA_CLEAR = 2'd0,
    TA_BNUM  = 2'd1,
    TA_IDX   = 2'd2,
    TA_WALK  = 2'd3
  } taddr_sel_e;

  typedef struct packed {
    logic       in_load;
    taddr_sel_e taddr_sel;
    logic       clear_wr;
    logic       idx_wr;
    logic       walk_start;
    logic       walk_run;
    logic       walk_wr;
    logic       push;
    logic       set_failed;
    logic       clr_list;
    logic       arm;
    logic       res_load;
    status_e    res_status;
    logic       res_tag_rd;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic list_op;
    logic owner_bad;
    logic contig_bad;
    logic bnum_oob;
    logic overflow;
    logic last;
    logic tbl_busy;
    logic armed;
    logic failed;
    logic walk_done;
    logic walk_busy;
    logic clear_done;
    logic out_free;
  } sts_t;

endpackage

### hdl/dbam_datapath.sv
// Datapath: owner table, pending list, walk pipeline and result registers.
module dbam_datapath
  import dbam_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [OWNER_W-1:0]  owner_id_i,
  input  logic [BLK_W-1:0]    start_block_i,
  input  logic [RUN_W-1:0]    run_length_i,
  input  logic [BLK_W-1:0]    block_number_i,
  input  logic                is_last_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [TAG_W-1:0]    block_tag_o
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  // Latched request
  logic [OPCODE_W-1:0] op_q;
  logic [OWNER_W-1:0]  owner_q;
  logic [BLK_W-1:0]    start_q;
  logic [RUN_W-1:0]    run_q;
  logic [BLK_W-1:0]    bnum_q;
  logic                last_q;

  // List state
  logic [CW-1:0] count_q;
  logic          failed_q;
  logic [AW-1:0] idx_q;
  logic          armed_q;

  // Walk pipeline
  logic [CW-1:0]    wi_q;
  logic             av_q;
  logic             bv_q;
  logic             busy_q;
  logic [BLK_W-1:0] plist_rd_q;
  logic [AW-1:0]    cblk_q;

  logic [BLK_W-1:0] plist_mem [NUM_BLOCKS];
  logic [TAG_W-1:0] tbl_mem   [NUM_BLOCKS];
  logic [TAG_W-1:0] tdata_q;

  logic [STATUS_W-1:0] res_status_q;
  logic [TAG_W-1:0]    res_tag_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [TAG_W-1:0]    out_tag_q;

  logic          list_op;
  logic          owner_bad;
  logic [CW-1:0] walk_len;
  logic          issue;
  logic [AW-1:0] wblk;
  logic [AW-1:0] taddr;
  logic          tbl_we;
  logic [TAG_W-1:0] tbl_wdata;

  assign list_op   = (op_q == OP_LINKED) || (op_q == OP_INDEXED);
  assign owner_bad = (owner_q == TAG_FREE) || (owner_q == TAG_INDEX);
  assign walk_len  = list_op ? count_q : CW'(run_q);
  assign issue     = cmd_i.walk_run && (wi_q != walk_len);
  assign wblk      = list_op ? AW'(plist_rd_q) : cblk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q    <= opcode_i;
      owner_q <= owner_id_i;
      start_q <= start_block_i;
      run_q   <= run_length_i;
      bnum_q  <= block_number_i;
      last_q  <= is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      failed_q <= 1'b0;
      idx_q    <= '0;
      armed_q  <= 1'b0;
    end else if (cmd_i.clr_list) begin
      count_q  <= '0;
      failed_q <= 1'b0;
      armed_q  <= 1'b0;
    end else begin
      if (cmd_i.push) count_q <= count_q + CW'(1);
      if (cmd_i.set_failed) failed_q <= 1'b1;
      if (cmd_i.arm) begin
        idx_q   <= AW'(bnum_q);
        armed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) plist_mem[count_q[AW-1:0]] <= bnum_q;
  end

  // Walk: stage A forms the block number, stage B reads or writes the table,
  // stage C checks the tag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q   <= '0;
      av_q   <= 1'b0;
      bv_q   <= 1'b0;
      busy_q <= 1'b0;
    end else if (cmd_i.walk_start) begin
      wi_q   <= '0;
      av_q   <= 1'b0;
      bv_q   <= 1'b0;
      busy_q <= 1'b0;
    end else if (cmd_i.clear_wr) begin
      wi_q <= wi_q + CW'(1);
    end else begin
      if (issue) wi_q <= wi_q + CW'(1);
      av_q <= issue;
      bv_q <= av_q;
      if (bv_q && (tdata_q != TAG_FREE)) busy_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    plist_rd_q <= plist_mem[wi_q[AW-1:0]];
    cblk_q     <= AW'(start_q) + wi_q[AW-1:0];
  end

  always_comb begin
    case (cmd_i.taddr_sel)
      TA_CLEAR: taddr = wi_q[AW-1:0];
      TA_BNUM:  taddr = AW'(bnum_q);
      TA_IDX:   taddr = idx_q;
      TA_WALK:  taddr = wblk;
      default:  taddr = wblk;
    endcase
  end

  assign tbl_we    = cmd_i.clear_wr || cmd_i.idx_wr || (cmd_i.walk_wr && av_q);
  assign tbl_wdata = cmd_i.clear_wr ? TAG_FREE : (cmd_i.idx_wr ? TAG_INDEX : owner_q);

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[taddr] <= tbl_wdata;
    tdata_q <= tbl_mem[taddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_tag_q    <= cmd_i.res_tag_rd ? tdata_q : TAG_FREE;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_tag_q    <= res_tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign block_tag_o = out_tag_q;

  assign sts_o.op         = op_e'(op_q);
  assign sts_o.list_op    = list_op;
  assign sts_o.owner_bad  = owner_bad;
  assign sts_o.contig_bad = owner_bad || (run_q == '0) ||
                            ((32'(start_q) + 32'(run_q)) > NUM_BLOCKS);
  assign sts_o.bnum_oob   = 32'(bnum_q) >= NUM_BLOCKS;
  assign sts_o.overflow   = count_q == CW'(NUM_BLOCKS);
  assign sts_o.last       = last_q;
  assign sts_o.tbl_busy   = tdata_q != TAG_FREE;
  assign sts_o.armed      = armed_q;
  assign sts_o.failed     = failed_q;
  assign sts_o.walk_done  = (wi_q == walk_len) && !av_q && !bv_q;
  assign sts_o.walk_busy  = busy_q;
  assign sts_o.clear_done = wi_q[AW-1:0] == AW'(NUM_BLOCKS - 1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### hdl/dbam_ctrl.sv
// Controller: sequences decode, table checks, commits and the response.
module dbam_ctrl
  import dbam_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_DECODE  = 12'b0000_0000_0100,
    S_ENTRY   = 12'b0000_0000_1000,
    S_COMMIT  = 12'b0000_0001_0000,
    S_IDXCHK  = 12'b0000_0010_0000,
    S_WALKCHK = 12'b0000_0100_0000,
    S_IDXWR   = 12'b0000_1000_0000,
    S_WALKWR  = 12'b0001_0000_0000,
    S_DECL    = 12'b0010_0000_0000,
    S_READ    = 12'b0100_0000_0000,
    S_RESP    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.taddr_sel = TA_WALK;
    cmd_o.res_status = ST_INVALID;

    case (state_q)
      S_CLEAR: begin
        cmd_o.taddr_sel = TA_CLEAR;
        cmd_o.clear_wr  = 1'b1;
        if (sts_i.clear_done) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_DECODE;
        end
      end

      S_DECODE: begin
        cmd_o.taddr_sel = TA_BNUM;
        case (sts_i.op)
          OP_CONTIG: begin
            if (sts_i.contig_bad) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_INVALID;
              state_d          = S_RESP;
            end else begin
              cmd_o.walk_start = 1'b1;
              state_d          = S_WALKCHK;
            end
          end
          OP_LINKED, OP_INDEXED: begin
            if (sts_i.overflow || sts_i.bnum_oob) begin
              cmd_o.set_failed = 1'b1;
              if (sts_i.last) begin
                state_d = S_COMMIT;
              end else begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = sts_i.overflow ? ST_INVALID : ST_PENDING;
                state_d          = S_RESP;
              end
            end else begin
              state_d = S_ENTRY;
            end
          end
          OP_INDEX_DECL: begin
            cmd_o.clr_list = 1'b1;
            if (sts_i.bnum_oob) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_INDEX_UNAV;
              state_d          = S_RESP;
            end else begin
              state_d = S_DECL;
            end
          end
          OP_READ: begin
            if (sts_i.bnum_oob) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_INVALID;
              state_d          = S_RESP;
            end else begin
              state_d = S_READ;
            end
          end
          default: begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_INVALID;
            state_d          = S_RESP;
          end
        endcase
      end

      S_ENTRY: begin
        if (sts_i.tbl_busy) begin
          cmd_o.set_failed = 1'b1;
        end else begin
          cmd_o.push = 1'b1;
        end
        if (sts_i.last) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_PENDING;
          state_d          = S_RESP;
        end
      end

      // Precedence: bad owner, then index, then blocks
      S_COMMIT: begin
        cmd_o.taddr_sel = TA_IDX;
        if (sts_i.owner_bad) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_INVALID;
          cmd_o.clr_list   = 1'b1;
          state_d          = S_RESP;
        end else if (sts_i.op == OP_INDEXED) begin
          if (!sts_i.armed) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_INDEX_UNAV;
            cmd_o.clr_list   = 1'b1;
            state_d          = S_RESP;
          end else begin
            state_d = S_IDXCHK;
          end
        end else if (sts_i.failed) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_BLOCKS_UNAV;
          cmd_o.clr_list   = 1'b1;
          state_d          = S_RESP;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_WALKCHK;
        end
      end

      S_IDXCHK: begin
        if (sts_i.tbl_busy) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_INDEX_UNAV;
          cmd_o.clr_list   = 1'b1;
          state_d          = S_RESP;
        end else if (sts_i.failed) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_BLOCKS_UNAV;
          cmd_o.clr_list   = 1'b1;
          state_d          = S_RESP;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_WALKCHK;
        end
      end

      // Check every block before any is claimed
      S_WALKCHK: begin
        cmd_o.walk_run = 1'b1;
        if (sts_i.walk_done) begin
          if (sts_i.walk_busy) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_BLOCKS_UNAV;
            cmd_o.clr_list   = sts_i.list_op;
            state_d          = S_RESP;
          end else begin
            cmd_o.walk_start = 1'b1;
            state_d          = (sts_i.op == OP_INDEXED) ? S_IDXWR : S_WALKWR;
          end
        end
      end

      // Tag the index first so a listed duplicate ends up with the owner
      S_IDXWR: begin
        cmd_o.taddr_sel = TA_IDX;
        cmd_o.idx_wr    = 1'b1;
        state_d         = S_WALKWR;
      end

      S_WALKWR: begin
        cmd_o.walk_run = 1'b1;
        cmd_o.walk_wr  = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.clr_list   = sts_i.list_op;
          state_d          = S_RESP;
        end
      end

      S_DECL: begin
        cmd_o.res_load = 1'b1;
        if (sts_i.tbl_busy) begin
          cmd_o.res_status = ST_INDEX_UNAV;
        end else begin
          cmd_o.arm        = 1'b1;
          cmd_o.res_status = ST_PENDING;
        end
        state_d = S_RESP;
      end

      S_READ: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_OK;
        cmd_o.res_tag_rd = 1'b1;
        state_d          = S_RESP;
      end

      // Hold the result until the output register is free
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/disk_block_allocation_map_top.sv
// Top level of the disk block allocation map.
//
//  channel  direction  handshake             payload
//  in       input      in_valid_i/in_ready_o  opcode, owner_id, start_block, run_length,
//                                            block_number, is_last
//  out      output     out_valid_o/out_ready_i status, block_tag
//
// One request is in work at a time; the result sits in an output register, so
// the next request is taken while it waits. A contiguous request walks its run
// twice through the single owner table port (check, then claim). A list commit
// walks the buffered entries the same way; an indexed list also checks its index
// block before the walk and tags it before the claim.
// After reset a clearing pass writes every table entry free, with in_ready_o
// low. A stalled output only delays the next response.
module disk_block_allocation_map_top
  import dbam_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [OWNER_W-1:0]  owner_id_i,
  input  logic [BLK_W-1:0]    start_block_i,
  input  logic [RUN_W-1:0]    run_length_i,
  input  logic [BLK_W-1:0]    block_number_i,
  input  logic                is_last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [TAG_W-1:0]    block_tag_o
);

  cmd_t cmd;
  sts_t sts;

  dbam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dbam_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (opcode_i),
    .owner_id_i     (owner_id_i),
    .start_block_i  (start_block_i),
    .run_length_i   (run_length_i),
    .block_number_i (block_number_i),
    .is_last_i      (is_last_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .block_tag_o    (block_tag_o)
  );

endmodule

### sim/testbench.sv
// Self-checking testbench for the disk block allocation map.
`timescale 1ns / 1ps

module testbench;
  import dbam_pkg::*;

  localparam int NBLK        = NUM_BLOCKS_DEF;
  localparam int RAND_ITEMS  = 1235;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_WAIT  = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [OWNER_W-1:0]  owner;
    logic [BLK_W-1:0]    sb;
    logic [RUN_W-1:0]    rl;
    logic [BLK_W-1:0]    bn;
    logic                fin;
  } req_t;

  typedef struct {
    status_e          st;
    logic [TAG_W-1:0] tag;
  } answer_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [OPCODE_W-1:0] opcode_i       = '0;
  logic [OWNER_W-1:0]  owner_id_i     = '0;
  logic [BLK_W-1:0]    start_block_i  = '0;
  logic [RUN_W-1:0]    run_length_i   = '0;
  logic [BLK_W-1:0]    block_number_i = '0;
  logic                is_last_i      = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [TAG_W-1:0]    block_tag_o;

  // Shadow of the allocation state
  logic [TAG_W-1:0] owner_tbl [NBLK];
  logic [BLK_W-1:0] held_blk  [NBLK];
  int               held_cnt  = 0;
  bit               held_bad  = 1'b0;
  logic [BLK_W-1:0] idx_blk   = '0;
  bit               idx_armed = 1'b0;

  answer_t answer_q [$];
  int      err_cnt    = 0;
  int      items_sent = 0;
  int      cycle_cnt  = 0;
  int      rx_wait    = 0;
  int      hold_left  = 0;
  bit      no_idle    = 1'b0;

  disk_block_allocation_map_top #(
    .NUM_BLOCKS(NBLK)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .owner_id_i    (owner_id_i),
    .start_block_i (start_block_i),
    .run_length_i  (run_length_i),
    .block_number_i(block_number_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .block_tag_o   (block_tag_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Allocation map predictor
  // ---------------------------------------------------------------------------
  function automatic status_e commit_list(input logic [OWNER_W-1:0] own, input bit indexed);
    status_e st;
    st = ST_OK;
    if (own == TAG_FREE || own == TAG_INDEX) begin
      st = ST_INVALID;
    end else if (indexed && (!idx_armed || owner_tbl[idx_blk] != TAG_FREE)) begin
      st = ST_INDEX_UNAV;
    end else begin
      if (held_bad) st = ST_BLOCKS_UNAV;
      for (int i = 0; i < held_cnt; i++)
        if (owner_tbl[held_blk[i]] != TAG_FREE) st = ST_BLOCKS_UNAV;
    end
    // Index first, so an index block that is also an entry ends up with the owner
    if (st == ST_OK) begin
      if (indexed) owner_tbl[idx_blk] = TAG_INDEX;
      for (int i = 0; i < held_cnt; i++) owner_tbl[held_blk[i]] = own;
    end
    held_cnt  = 0;
    held_bad  = 1'b0;
    idx_armed = 1'b0;
    return st;
  endfunction

  function automatic status_e list_step(input req_t r, input bit indexed);
    bit ovf;
    ovf = held_cnt >= NBLK;
    if (ovf || owner_tbl[r.bn] != TAG_FREE) begin
      held_bad = 1'b1;
    end else begin
      held_blk[held_cnt] = r.bn;
      held_cnt++;
    end
    if (r.fin) return commit_list(r.owner, indexed);
    return ovf ? ST_INVALID : ST_PENDING;
  endfunction

  function automatic answer_t map_step(input req_t r);
    answer_t a;
    a.st  = ST_INVALID;
    a.tag = TAG_FREE;
    case (r.op)
      OP_CONTIG: begin
        if (r.owner != TAG_FREE && r.owner != TAG_INDEX && r.rl != 0 &&
            int'(r.sb) + int'(r.rl) <= NBLK) begin
          a.st = ST_OK;
          for (int i = int'(r.sb); i < int'(r.sb) + int'(r.rl); i++)
            if (owner_tbl[i] != TAG_FREE) a.st = ST_BLOCKS_UNAV;
          if (a.st == ST_OK)
            for (int i = int'(r.sb); i < int'(r.sb) + int'(r.rl); i++) owner_tbl[i] = r.owner;
        end
      end
      OP_LINKED: a.st = list_step(r, 1'b0);
      OP_INDEX_DECL: begin
        held_cnt  = 0;
        held_bad  = 1'b0;
        idx_armed = 1'b0;
        if (owner_tbl[r.bn] != TAG_FREE) begin
          a.st = ST_INDEX_UNAV;
        end else begin
          idx_blk   = r.bn;
          idx_armed = 1'b1;
          a.st      = ST_PENDING;
        end
      end
      OP_INDEXED: a.st = list_step(r, 1'b1);
      OP_READ: begin
        a.st  = ST_OK;
        a.tag = owner_tbl[r.bn];
      end
      default: ;
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic send_req(input req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= r.op;
    owner_id_i     <= r.owner;
    start_block_i  <= r.sb;
    run_length_i   <= r.rl;
    block_number_i <= r.bn;
    is_last_i      <= r.fin;
    do @(posedge clk_i); while (!in_ready_o);
    answer_q.push_back(map_step(r));
    items_sent++;
  endtask

  function automatic req_t rand_req();
    req_t r;
    r.op    = OPCODE_W'($urandom_range(0, 7));
    r.owner = OWNER_W'($urandom_range(0, 255));
    r.sb    = BLK_W'($urandom_range(0, NBLK - 1));
    r.rl    = RUN_W'($urandom_range(0, 127));
    r.bn    = BLK_W'($urandom_range(0, NBLK - 1));
    r.fin   = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_contig(input logic [OWNER_W-1:0] own, input logic [BLK_W-1:0] sb,
                             input logic [RUN_W-1:0] rl);
    req_t r;
    r       = rand_req();
    r.op    = OP_CONTIG;
    r.owner = own;
    r.sb    = sb;
    r.rl    = rl;
    send_req(r);
  endtask

  task automatic send_entry(input op_e op, input logic [BLK_W-1:0] bn,
                            input logic [OWNER_W-1:0] own, input logic fin);
    req_t r;
    r       = rand_req();
    r.op    = op;
    r.bn    = bn;
    r.owner = own;
    r.fin   = fin;
    send_req(r);
  endtask

  task automatic send_decl(input logic [BLK_W-1:0] bn);
    req_t r;
    r    = rand_req();
    r.op = OP_INDEX_DECL;
    r.bn = bn;
    send_req(r);
  endtask

  task automatic send_read(input logic [BLK_W-1:0] bn);
    req_t r;
    r    = rand_req();
    r.op = OP_READ;
    r.bn = bn;
    send_req(r);
  endtask

  // Mostly a free block, so that lists get past their checks
  function automatic logic [BLK_W-1:0] pick_block();
    int free_ids [$];
    foreach (owner_tbl[i]) if (owner_tbl[i] == TAG_FREE) free_ids.push_back(i);
    if (free_ids.size() != 0 && $urandom_range(0, 9) < 8)
      return BLK_W'(free_ids[$urandom_range(0, free_ids.size() - 1)]);
    return BLK_W'($urandom_range(0, NBLK - 1));
  endfunction

  function automatic logic [OWNER_W-1:0] any_owner();
    case ($urandom_range(0, 19))
      0:       return TAG_FREE;
      1:       return TAG_INDEX;
      2:       return OWNER_W'($urandom_range(0, 255));
      default: return OWNER_W'($urandom_range(1, 254));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    answer_t exp_a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", int'(status_o), -1);
      end else begin
        exp_a = answer_q.pop_front();
        if (status_o !== exp_a.st)
          report_mismatch("status", int'(status_o), int'(exp_a.st));
        if (block_tag_o !== exp_a.tag)
          report_mismatch("block_tag", int'(block_tag_o), int'(exp_a.tag));
      end
      rx_wait = no_idle ? 0 : $urandom_range(0, 5);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_contig_and_read();
    req_t r;
    send_read(6'd0);
    send_contig(8'd1, 6'd0, 7'd1);
    send_contig(8'd254, 6'd60, 7'd4);      // run ends exactly at the last block
    send_contig(TAG_FREE, 6'd10, 7'd2);
    send_contig(TAG_INDEX, 6'd10, 7'd2);
    send_contig(8'd5, 6'd10, 7'd0);
    send_contig(8'd5, 6'd63, 7'd2);        // runs off the end
    send_contig(8'd5, 6'd0, 7'd64);        // whole disk, block 0 taken
    send_contig(8'd5, 6'd63, 7'd127);
    r    = rand_req();
    r.op = 3'd5;
    send_req(r);
    r    = rand_req();
    r.op = 3'd7;
    send_req(r);
    send_read(6'd63);
  endtask

  task automatic test_lists();
    send_entry(OP_LINKED, 6'd5, 8'd3, 1'b0);
    send_entry(OP_LINKED, 6'd6, 8'd9, 1'b1);
    send_read(6'd6);
    send_entry(OP_LINKED, 6'd0, 8'd9, 1'b0);   // taken block poisons the list
    send_entry(OP_LINKED, 6'd7, 8'd10, 1'b1);
    send_decl(6'd20);
    send_entry(OP_INDEXED, 6'd21, 8'd30, 1'b1);
    send_read(6'd20);
    send_decl(6'd20);                          // index block now in use
    send_entry(OP_INDEXED, 6'd30, 8'd31, 1'b1); // no index declared
    send_entry(OP_LINKED, 6'd31, TAG_INDEX, 1'b1);
  endtask

  task automatic test_list_corners();
    // Index block taken between declare and commit
    send_decl(6'd40);
    send_contig(8'd7, 6'd40, 7'd1);
    send_entry(OP_INDEXED, 6'd42, 8'd8, 1'b1);
    // Buffered entry taken before commit
    send_entry(OP_LINKED, 6'd43, 8'd0, 1'b0);
    send_contig(8'd7, 6'd43, 7'd1);
    send_entry(OP_LINKED, 6'd44, 8'd9, 1'b1);
    // Index block also an entry, mixed opcodes, duplicate entry
    send_decl(6'd45);
    send_entry(OP_INDEXED, 6'd45, 8'd0, 1'b0);
    send_entry(OP_LINKED, 6'd46, 8'd0, 1'b0);
    send_entry(OP_INDEXED, 6'd46, 8'd11, 1'b1);
    send_read(6'd45);
    // Linked commit drops the declared index
    send_decl(6'd47);
    send_entry(OP_LINKED, 6'd48, 8'd12, 1'b1);
    send_read(6'd47);
  endtask

  task automatic test_list_overflow();
    repeat (NBLK) send_entry(OP_LINKED, 6'd50, OWNER_W'($urandom_range(0, 255)), 1'b0);
    send_entry(OP_LINKED, 6'd50, 8'd13, 1'b0);
    send_entry(OP_LINKED, 6'd50, 8'd13, 1'b1);
  endtask

  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    no_idle   = 1'b1;
    repeat (12) send_read(BLK_W'($urandom_range(0, NBLK - 1)));
    no_idle   = 1'b0;
  endtask

  task automatic test_random_traffic();
    int      base;
    int      kind;
    int      len;
    logic    [BLK_W-1:0] idx;
    req_t    r;
    base = items_sent;
    while (items_sent - base < RAND_ITEMS) begin
      no_idle = (items_sent - base >= 500) && (items_sent - base < 650);
      kind    = $urandom_range(0, 99);
      if (kind < 15) begin
        case ($urandom_range(0, 5))
          0:       send_contig(any_owner(), BLK_W'($urandom_range(0, NBLK - 1)),
                               RUN_W'($urandom_range(0, 127)));
          1:       send_contig(any_owner(), pick_block(), RUN_W'($urandom_range(1, NBLK)));
          default: send_contig(any_owner(), pick_block(), RUN_W'($urandom_range(1, 3)));
        endcase
      end else if (kind < 45) begin
        len = $urandom_range(1, 6);
        for (int i = 1; i <= len; i++)
          send_entry(OP_LINKED, pick_block(),
                     (i == len) ? any_owner() : OWNER_W'($urandom_range(0, 255)), i == len);
      end else if (kind < 70) begin
        idx = pick_block();
        if ($urandom_range(0, 9) != 0) send_decl(idx);
        len = $urandom_range(1, 5);
        for (int i = 1; i <= len; i++) begin
          if (i == len)
            send_entry(($urandom_range(0, 9) == 0) ? OP_LINKED : OP_INDEXED,
                       ($urandom_range(0, 9) == 0) ? idx : pick_block(), any_owner(), 1'b1);
          else
            send_entry(($urandom_range(0, 9) == 0) ? OP_LINKED : OP_INDEXED,
                       ($urandom_range(0, 9) == 0) ? idx : pick_block(),
                       OWNER_W'($urandom_range(0, 255)), 1'b0);
        end
      end else if (kind < 88) begin
        send_read(BLK_W'($urandom_range(0, NBLK - 1)));
      end else begin
        // Noise: unknown opcodes, abandoned list heads, stray declares
        r = rand_req();
        case ($urandom_range(0, 2))
          0: r.op = OPCODE_W'($urandom_range(5, 7));
          1: begin
            r.op  = $urandom_range(0, 1) ? OP_LINKED : OP_INDEXED;
            r.bn  = pick_block();
            r.fin = 1'b0;
          end
          default: r.op = OP_INDEX_DECL;
        endcase
        send_req(r);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (owner_tbl[i]) owner_tbl[i] = TAG_FREE;
    foreach (held_blk[i]) held_blk[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_contig_and_read();
    test_lists();
    test_list_corners();
    test_list_overflow();
    test_backpressure();
    test_random_traffic();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
